### src/two_generation_block_cache_directory_macros.svh
// Assertion macros used by the directory controller.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef TWO_GENERATION_BLOCK_CACHE_DIRECTORY_MACROS_SVH
`define TWO_GENERATION_BLOCK_CACHE_DIRECTORY_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define TGBCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define TGBCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### src/tgbcd_pkg.sv
package tgbcd_pkg;

  localparam int SLOT_W = 6;

  // Input actions.
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_FLUSH = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_HIT   = 3'd0;
  localparam logic [2:0] KIND_FILL  = 3'd1;
  localparam logic [2:0] KIND_WB    = 3'd2;
  localparam logic [2:0] KIND_ERR   = 3'd3;
  localparam logic [2:0] KIND_PRES  = 3'd4;
  localparam logic [2:0] KIND_FDONE = 3'd5;

  // Block size limits (log2 of bytes).
  localparam logic [4:0] SHIFT_MIN   = 5'd9;
  localparam logic [4:0] SHIFT_MAX   = 5'd16;
  localparam logic [4:0] SHIFT_RESET = 5'd12;

  typedef struct packed {
    logic [1:0]  action;
    logic [8:0]  area_id;
    logic [31:0] offset;
    logic [16:0] length;
  } req_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [8:0]        result_area;
    logic [31:0]       block_address;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       offset_in_block;
    logic              found;
    logic              last;
  } res_t;

  // One result offered by the sequencer to the output register.
  typedef struct packed {
    logic vld;
    res_t res;
  } emit_t;

endpackage

### src/tgbcd_ram.sv
module tgbcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/tgbcd_ctrl.sv
`include "two_generation_block_cache_directory_macros.svh"

module tgbcd_ctrl #(
  parameter int SLOTS_PER_BANK = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tgbcd_pkg::req_t     in_req,
  output logic                idle,
  input  logic [4:0]          block_shift,
  output tgbcd_pkg::emit_t    emit,
  input  logic                emit_ok,
  output logic                ram_we,
  output logic [$clog2(2*SLOTS_PER_BANK)-1:0] ram_waddr,
  output logic [31:0]         ram_wdata,
  output logic                ram_re,
  output logic [$clog2(2*SLOTS_PER_BANK)-1:0] ram_raddr,
  input  logic [31:0]         ram_rdata
);

  localparam int NUM = 2 * SLOTS_PER_BANK;
  localparam int AW  = $clog2(NUM);
  localparam int KW  = $clog2(NUM + 1);
  localparam int FW  = $clog2(SLOTS_PER_BANK + 1);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_FIND    = 7'b0000010,
    ST_WB_SCAN = 7'b0000100,
    ST_WB_READ = 7'b0001000,
    ST_WB_END  = 7'b0010000,
    ST_FILL    = 7'b0100000,
    ST_RESP    = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [KW-1:0]   pos_r, pos_nxt;
  logic            p_vld_r, p_vld_nxt;
  logic [AW-1:0]   p_slot_r, p_slot_nxt;
  logic [AW-1:0]   rd_slot_r, rd_slot_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [31:0]     pend_tag_r, pend_tag_nxt;
  logic [AW-1:0]   pend_slot_r, pend_slot_nxt;
  logic [AW-1:0]   hit_slot_r, hit_slot_nxt;
  logic            found_r, found_nxt;
  logic            flush_r, flush_nxt;
  logic [1:0]      act_r, act_nxt;
  logic [8:0]      area_r, area_nxt;
  logic [31:0]     blkaddr_r, blkaddr_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [15:0]     oib_r, oib_nxt;
  logic [15:0]     mask_r, mask_nxt;
  logic            fit_r, fit_nxt;
  logic [NUM-1:0]  valid_r, valid_nxt;
  logic [NUM-1:0]  dirty_r, dirty_nxt;
  logic            new_bank_r, new_bank_nxt;
  logic [FW-1:0]   fill_cnt_r, fill_cnt_nxt;

  logic [4:0]      eff_shift;
  logic [15:0]     in_mask;
  logic [31:0]     in_blkaddr;
  logic [15:0]     in_oib;
  logic [KW-1:0]   pos_tmp;
  logic [AW-1:0]   pos_slot;
  logic [AW-1:0]   fill_slot;
  logic [NUM-1:0]  old_mask;
  logic [KW-1:0]   scan_end;
  logic            match;
  tgbcd_pkg::res_t wb_res;

  // Block geometry of the incoming item at the current block size.
  always_comb begin
    if (block_shift < tgbcd_pkg::SHIFT_MIN) begin
      eff_shift = tgbcd_pkg::SHIFT_MIN;
    end else if (block_shift > tgbcd_pkg::SHIFT_MAX) begin
      eff_shift = tgbcd_pkg::SHIFT_MAX;
    end else begin
      eff_shift = block_shift;
    end
    in_mask    = 16'((17'd1 << eff_shift) - 17'd1);
    in_blkaddr = in_req.offset & ~{16'h0000, in_mask};
    in_oib     = in_req.offset[15:0] & in_mask;
  end

  // Scan position to slot: the old bank comes first, then the new bank.
  always_comb begin
    if (new_bank_r) begin
      pos_tmp = pos_r;
    end else if (pos_r < KW'(SLOTS_PER_BANK)) begin
      pos_tmp = pos_r + KW'(SLOTS_PER_BANK);
    end else begin
      pos_tmp = pos_r - KW'(SLOTS_PER_BANK);
    end
    pos_slot = pos_tmp[AW-1:0];
  end

  assign fill_slot = new_bank_r ? (AW'(SLOTS_PER_BANK) + AW'(fill_cnt_r)) : AW'(fill_cnt_r);
  assign scan_end  = flush_r ? KW'(NUM) : KW'(SLOTS_PER_BANK);
  assign match     = p_vld_r && valid_r[p_slot_r] && (ram_rdata == key_r);
  assign idle      = (state_r == ST_IDLE);

  always_comb begin
    for (int i = 0; i < NUM; i++) begin
      old_mask[i] = ((i >= SLOTS_PER_BANK) != new_bank_r);
    end
  end

  always_comb begin
    wb_res                 = '0;
    wb_res.kind            = tgbcd_pkg::KIND_WB;
    wb_res.result_area     = pend_tag_r[8:0] & mask_r[8:0];
    wb_res.block_address   = pend_tag_r & ~{16'h0000, mask_r};
    wb_res.slot            = tgbcd_pkg::SLOT_W'(pend_slot_r);
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    p_vld_nxt     = p_vld_r;
    p_slot_nxt    = p_slot_r;
    rd_slot_nxt   = rd_slot_r;
    pend_v_nxt    = pend_v_r;
    pend_tag_nxt  = pend_tag_r;
    pend_slot_nxt = pend_slot_r;
    hit_slot_nxt  = hit_slot_r;
    found_nxt     = found_r;
    flush_nxt     = flush_r;
    act_nxt       = act_r;
    area_nxt      = area_r;
    blkaddr_nxt   = blkaddr_r;
    key_nxt       = key_r;
    oib_nxt       = oib_r;
    mask_nxt      = mask_r;
    fit_nxt       = fit_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    new_bank_nxt  = new_bank_r;
    fill_cnt_nxt  = fill_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = fill_slot;
    ram_wdata     = key_r;
    ram_re        = 1'b0;
    ram_raddr     = pos_slot;
    emit          = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_req.action;
          area_nxt    = in_req.area_id;
          blkaddr_nxt = in_blkaddr;
          key_nxt     = in_blkaddr | {23'h0, in_req.area_id};
          oib_nxt     = in_oib;
          mask_nxt    = in_mask;
          fit_nxt     = ({2'b00, in_oib} + {1'b0, in_req.length}) <=
                        ({2'b00, in_mask} + 18'd1);
          pos_nxt     = '0;
          p_vld_nxt   = 1'b0;
          pend_v_nxt  = 1'b0;
          found_nxt   = 1'b0;
          if (in_req.action == tgbcd_pkg::ACT_FLUSH) begin
            flush_nxt = 1'b1;
            state_nxt = ST_WB_SCAN;
          end else begin
            flush_nxt = 1'b0;
            state_nxt = ST_FIND;
          end
        end
      end

      // One tag read per cycle; the compare is made in the cycle after the read.
      ST_FIND: begin
        if (match) begin
          hit_slot_nxt = p_slot_r;
          found_nxt    = 1'b1;
          p_vld_nxt    = 1'b0;
          state_nxt    = ST_RESP;
        end else if (pos_r != KW'(NUM)) begin
          ram_re     = 1'b1;
          p_vld_nxt  = 1'b1;
          p_slot_nxt = pos_slot;
          pos_nxt    = pos_r + KW'(1);
        end else begin
          p_vld_nxt = 1'b0;
          if (act_r == tgbcd_pkg::ACT_QUERY) begin
            state_nxt = ST_RESP;
          end else if (fill_cnt_r >= FW'(SLOTS_PER_BANK)) begin
            pos_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = ST_WB_SCAN;
          end else begin
            state_nxt = ST_FILL;
          end
        end
      end

      ST_WB_SCAN: begin
        if (pos_r == scan_end) begin
          state_nxt = ST_WB_END;
        end else begin
          pos_nxt = pos_r + KW'(1);
          if (valid_r[pos_slot] && dirty_r[pos_slot]) begin
            ram_re      = 1'b1;
            rd_slot_nxt = pos_slot;
            state_nxt   = ST_WB_READ;
          end
        end
      end

      // The previous write-back goes out only once the next one is known,
      // so the final one of a flush can carry the last flag.
      ST_WB_READ: begin
        if (pend_v_r) begin
          emit.vld = 1'b1;
          emit.res = wb_res;
          if (emit_ok) begin
            pend_tag_nxt  = ram_rdata;
            pend_slot_nxt = rd_slot_r;
            state_nxt     = ST_WB_SCAN;
          end
        end else begin
          pend_v_nxt    = 1'b1;
          pend_tag_nxt  = ram_rdata;
          pend_slot_nxt = rd_slot_r;
          state_nxt     = ST_WB_SCAN;
        end
      end

      ST_WB_END: begin
        if (pend_v_r) begin
          emit.vld      = 1'b1;
          emit.res      = wb_res;
          emit.res.last = flush_r;
        end else if (flush_r) begin
          emit.vld      = 1'b1;
          emit.res.kind = tgbcd_pkg::KIND_FDONE;
          emit.res.last = 1'b1;
        end
        if (emit_ok || !emit.vld) begin
          pend_v_nxt = 1'b0;
          if (flush_r) begin
            state_nxt = ST_IDLE;
          end else begin
            // Drop the old generation and swap the roles of the banks.
            valid_nxt    = valid_r & ~old_mask;
            dirty_nxt    = dirty_r & ~old_mask;
            new_bank_nxt = ~new_bank_r;
            fill_cnt_nxt = '0;
            state_nxt    = ST_FILL;
          end
        end
      end

      ST_FILL: begin
        emit.vld               = 1'b1;
        emit.res.kind          = tgbcd_pkg::KIND_FILL;
        emit.res.result_area   = area_r;
        emit.res.block_address = blkaddr_r;
        emit.res.slot          = tgbcd_pkg::SLOT_W'(fill_slot);
        if (emit_ok) begin
          ram_we               = 1'b1;
          valid_nxt[fill_slot] = 1'b1;
          dirty_nxt[fill_slot] = 1'b0;
          fill_cnt_nxt         = fill_cnt_r + FW'(1);
          hit_slot_nxt         = fill_slot;
          state_nxt            = ST_RESP;
        end
      end

      ST_RESP: begin
        emit.vld                 = 1'b1;
        emit.res.result_area     = area_r;
        emit.res.block_address   = blkaddr_r;
        emit.res.offset_in_block = oib_r;
        emit.res.last            = 1'b1;
        if (act_r == tgbcd_pkg::ACT_QUERY) begin
          emit.res.kind  = tgbcd_pkg::KIND_PRES;
          emit.res.found = found_r;
          emit.res.slot  = found_r ? tgbcd_pkg::SLOT_W'(hit_slot_r) : '0;
        end else begin
          emit.res.kind = fit_r ? tgbcd_pkg::KIND_HIT : tgbcd_pkg::KIND_ERR;
          emit.res.slot = tgbcd_pkg::SLOT_W'(hit_slot_r);
        end
        if (emit_ok) begin
          if (fit_r && (act_r == tgbcd_pkg::ACT_WRITE)) begin
            dirty_nxt[hit_slot_r] = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      p_vld_r    <= 1'b0;
      pend_v_r   <= 1'b0;
      valid_r    <= '0;
      dirty_r    <= '0;
      new_bank_r <= 1'b0;
      fill_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      p_vld_r    <= p_vld_nxt;
      pend_v_r   <= pend_v_nxt;
      valid_r    <= valid_nxt;
      dirty_r    <= dirty_nxt;
      new_bank_r <= new_bank_nxt;
      fill_cnt_r <= fill_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    p_slot_r    <= p_slot_nxt;
    rd_slot_r   <= rd_slot_nxt;
    pend_tag_r  <= pend_tag_nxt;
    pend_slot_r <= pend_slot_nxt;
    hit_slot_r  <= hit_slot_nxt;
    found_r     <= found_nxt;
    flush_r     <= flush_nxt;
    act_r       <= act_nxt;
    area_r      <= area_nxt;
    blkaddr_r   <= blkaddr_nxt;
    key_r       <= key_nxt;
    oib_r       <= oib_nxt;
    mask_r      <= mask_nxt;
    fit_r       <= fit_nxt;
  end

  `TGBCD_ASSERT_IMP(a_idle_quiet, state_r == ST_IDLE, !emit.vld,
    "result offered while no item is in progress")
  `TGBCD_ASSERT(a_fill_bound, fill_cnt_r <= FW'(SLOTS_PER_BANK),
    "new generation fill count beyond bank size")
  `TGBCD_ASSERT_IMP(a_wb_dirty, state_r == ST_WB_READ,
    valid_r[rd_slot_r] && dirty_r[rd_slot_r],
    "write-back read of a slot that is not valid and dirty")
  `TGBCD_ASSERT(a_fill_then_resp, (state_r == ST_FILL) && emit_ok |=> (state_r == ST_RESP),
    "fill not followed by the access response")

endmodule

### src/two_generation_block_cache_directory.sv
// Directory of a two-generation block cache over numbered storage areas.
// Input channel (in_valid, in_stall, in_data): one item per read, write,
// presence query or flush. An item is taken when in_valid is high and
// in_stall is low; in_stall stays high from acceptance until the item's
// final result has been handed to the output register.
// Result channel (out_valid, out_stall, out_data): every result item carries
// its kind, and the final result of an input item has last set.
// Configuration: cfg_wr_en with cfg_wr_data writes the block size (log2 of
// bytes); write it only while no item is in progress. Reset value is 12.
// Timing: a lookup reads one tag per cycle from a tag memory with one read
// port and one write port. A flush walks all 2*SLOTS_PER_BANK slots and
// reads the tag of each dirty block; a generation swap walks SLOTS_PER_BANK
// slots the same way before the fill. The write-back emission rate is
// bounded by that one tag read port.
// Reset (synchronous, active low) clears all valid and dirty marks, the
// generation pointer and fill count at once; no clearing pass is needed.
// When the receiver stalls, the output register holds its item and the
// sequencer waits on that result before moving on.
module two_generation_block_cache_directory #(
  parameter int SLOTS_PER_BANK = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tgbcd_pkg::req_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output tgbcd_pkg::res_t out_data,
  input  logic            cfg_wr_en,
  input  logic [4:0]      cfg_wr_data
);

  localparam int NUM = 2 * SLOTS_PER_BANK;
  localparam int AW  = $clog2(NUM);

  logic             ctrl_idle;
  tgbcd_pkg::emit_t emit;
  logic             emit_ok;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [31:0]      ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [31:0]      ram_rdata;

  logic [4:0]       block_shift_r;
  logic             out_valid_r, out_valid_nxt;
  tgbcd_pkg::res_t  out_data_r, out_data_nxt;

  // The block is busy for the whole life of an item.
  assign in_stall = !ctrl_idle;

  // The output register takes a new result whenever it is empty or
  // being drained in this same cycle.
  assign emit_ok = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit.vld && emit_ok) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit.res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      block_shift_r <= tgbcd_pkg::SHIFT_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        block_shift_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Tag memory: contents are only used where the slot's valid mark is set.
  tgbcd_ram #(
    .WIDTH (32),
    .DEPTH (NUM)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tgbcd_ctrl #(
    .SLOTS_PER_BANK (SLOTS_PER_BANK)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req      (in_data),
    .idle        (ctrl_idle),
    .block_shift (block_shift_r),
    .emit        (emit),
    .emit_ok     (emit_ok),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

endmodule
